/* src/quaternion_to_euler_xyz_defines.svh */
`ifndef QUATERNION_TO_EULER_XYZ_DEFINES_SVH
`define QUATERNION_TO_EULER_XYZ_DEFINES_SVH

// same-cycle implication under the async reset
`define Q2E_ASSERT_IMP(name, clk, rst_n, a, b) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("q2e implication check failed");

// delayed implication: when a holds, b must hold after the delay given by n
`define Q2E_ASSERT_DLY(name, clk, rst_n, a, n, b) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> ##n (b)) \
        else $error("q2e latency check failed");

`endif

/* src/q2e_pkg.sv */
`timescale 1ns / 1ps

package q2e_pkg;

    localparam int SUM_W        = 35;
    localparam int Z_W          = 35;
    localparam int V_W          = 32;
    localparam int CORDIC_W     = 64;
    localparam int CORDIC_ITERS = 30;
    localparam int NORM_MSB     = 59;
    localparam int SH_W         = 6;
    localparam int ISQRT_W      = 64;
    localparam int ISQRT_STAGES = 31;
    localparam int ROOT_W       = 31;
    localparam int ATAN_LAT     = CORDIC_ITERS + 4;
    localparam int ANGLE_W      = 25;

    localparam logic signed [Z_W-1:0] Q30_PI      = 35'sd3373259426;
    localparam logic signed [Z_W-1:0] Q30_HALF_PI = 35'sd1686629713;
    localparam logic signed [SUM_W-1:0] Q30_ONE   = 35'sd1073741824;
    localparam logic [29:0] DEG_PER_RAD_Q24       = 30'd961263669;

    typedef struct packed {
        logic signed [SUM_W-1:0] psi_y;
        logic signed [SUM_W-1:0] psi_x;
        logic signed [SUM_W-1:0] phi_y;
        logic signed [SUM_W-1:0] phi_x;
        logic signed [V_W-1:0]   v;
        logic                    clamped;
    } side_t;

    // floor(atan(2^-i) * 2^30)
    function automatic logic [29:0] atan_q30(input int i);
        case (i)
            0:  atan_q30 = 30'd843314856;
            1:  atan_q30 = 30'd497837829;
            2:  atan_q30 = 30'd263043836;
            3:  atan_q30 = 30'd133525158;
            4:  atan_q30 = 30'd67021686;
            5:  atan_q30 = 30'd33543515;
            6:  atan_q30 = 30'd16775850;
            7:  atan_q30 = 30'd8388437;
            8:  atan_q30 = 30'd4194282;
            9:  atan_q30 = 30'd2097149;
            10: atan_q30 = 30'd1048575;
            11: atan_q30 = 30'd524287;
            12: atan_q30 = 30'd262143;
            13: atan_q30 = 30'd131071;
            14: atan_q30 = 30'd65535;
            15: atan_q30 = 30'd32767;
            16: atan_q30 = 30'd16383;
            17: atan_q30 = 30'd8191;
            18: atan_q30 = 30'd4095;
            19: atan_q30 = 30'd2047;
            20: atan_q30 = 30'd1023;
            21: atan_q30 = 30'd511;
            22: atan_q30 = 30'd255;
            23: atan_q30 = 30'd127;
            24: atan_q30 = 30'd63;
            25: atan_q30 = 30'd31;
            26: atan_q30 = 30'd15;
            27: atan_q30 = 30'd7;
            28: atan_q30 = 30'd3;
            29: atan_q30 = 30'd1;
            default: atan_q30 = 30'd0;
        endcase
    endfunction

endpackage

/* src/quaternion_to_euler_xyz.sv */
`timescale 1ns / 1ps

// Quaternion (x, y, z, w) to XYZ Euler angles psi, theta, phi. A fully pipelined
// datapath: one quaternion may be started in every cycle and busy stays low.
// Each result is shown on done for exactly one cycle; the receiver cannot stall
// it, so it must take every word as it comes. The pipeline holds 5 front stages
// (products, sums, asin saturation, square, 1 - v^2), a 31-stage square root, a
// 34-stage CORDIC atan2 (prepare, shift count, scaling, 30 rotations, result
// register) and 2 output stages for the radian/degree scaling. cfg_wdata is
// written into the angles_in_degrees bit on cfg_we and should only change while
// no word is in flight. asin_clamped marks a non-unit quaternion whose asin
// argument was saturated to +/-1.

`include "quaternion_to_euler_xyz_defines.svh"

module quaternion_to_euler_xyz #(
    parameter int ANGLE_FRAC_BITS = 16,
    parameter int QUAT_WIDTH      = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  cfg_we,
    input  logic                                  cfg_wdata,
    input  logic signed [QUAT_WIDTH-1:0]          quat_x,
    input  logic signed [QUAT_WIDTH-1:0]          quat_y,
    input  logic signed [QUAT_WIDTH-1:0]          quat_z,
    input  logic signed [QUAT_WIDTH-1:0]          quat_w,
    output logic                                  done,
    output logic signed [q2e_pkg::ANGLE_W-1:0]    angle_psi,
    output logic signed [q2e_pkg::ANGLE_W-1:0]    angle_theta,
    output logic signed [q2e_pkg::ANGLE_W-1:0]    angle_phi,
    output logic                                  asin_clamped
);

    localparam int SW     = q2e_pkg::SUM_W;
    localparam int VW     = q2e_pkg::V_W;
    localparam int ZW     = q2e_pkg::Z_W;
    localparam int AW     = q2e_pkg::ANGLE_W;
    localparam int SC_W   = ZW + 31;
    localparam int PROD_W = 32;
    localparam int FB     = 2 * (QUAT_WIDTH - 1);
    localparam int SH_R   = (FB >= 30) ? FB - 30 : 0;
    localparam int SH_L   = (FB >= 30) ? 0 : 30 - FB;
    localparam int FRONT  = 5;
    localparam int TOTAL_LAT = FRONT + q2e_pkg::ISQRT_STAGES + q2e_pkg::ATAN_LAT + 2;
    localparam int SQ_LAST   = q2e_pkg::ISQRT_STAGES - 1;
    localparam logic signed [SC_W-1:0] RND_RAD = SC_W'(1) <<< (29 - ANGLE_FRAC_BITS);
    localparam logic signed [SC_W-1:0] RND_DEG = SC_W'(1) <<< (53 - ANGLE_FRAC_BITS);
    localparam logic signed [30:0]     DEG_K   = {1'b0, q2e_pkg::DEG_PER_RAD_Q24};

    // product of two components at 30 fractional bits, floor on right shift
    function automatic logic signed [PROD_W-1:0] mul_q30(
        input logic signed [QUAT_WIDTH-1:0] a,
        input logic signed [QUAT_WIDTH-1:0] b
    );
        logic signed [2*QUAT_WIDTH-1:0] p;
        logic signed [63:0]             pe;
        p  = a * b;
        pe = 64'(p);
        pe = (pe >>> SH_R) <<< SH_L;
        return pe[PROD_W-1:0];
    endfunction

    logic deg_reg;
    logic vld_reg [TOTAL_LAT];

    // stage 1: products
    logic signed [PROD_W-1:0] xx_reg, yy_reg, zz_reg, ww_reg, xw_reg;
    logic signed [PROD_W-1:0] yz_reg, xz_reg, yw_reg, zw_reg, xy_reg;

    // stage 2: sums
    logic signed [SW-1:0] psi_y_reg, psi_x_reg, phi_y_reg, phi_x_reg, vsum_reg;

    // stages 3..5
    q2e_pkg::side_t s3_next, s3_reg, s4_reg, s5_reg;
    logic [30:0]                    vmag;
    logic [61:0]                    vsq_reg;
    logic [q2e_pkg::ISQRT_W-1:0]    rad_reg;
    logic [q2e_pkg::ROOT_W-1:0]     root;

    q2e_pkg::side_t side_dly_reg [q2e_pkg::ISQRT_STAGES];
    logic           clamp_dly_reg [q2e_pkg::ATAN_LAT];

    logic signed [SW-1:0] theta_y, theta_x;
    logic signed [ZW-1:0] z_lane [3];
    logic signed [SC_W-1:0] scaled_reg [3];
    logic signed [SC_W-1:0] rounded [3];
    logic signed [AW-1:0]   angle_reg [3];
    logic deg_e1_reg;
    logic clamp_e1_reg;
    logic clamp_out_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            deg_reg <= 1'b0;
        else if (cfg_we)
            deg_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TOTAL_LAT; i++)
                vld_reg[i] <= 1'b0;
            clamp_out_reg <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= start && !busy;
            for (int i = 1; i < TOTAL_LAT; i++)
                vld_reg[i] <= vld_reg[i-1];
            clamp_out_reg <= clamp_e1_reg && vld_reg[TOTAL_LAT-2];
        end
    end

    always_ff @(posedge clk)
    begin
        xx_reg <= mul_q30(quat_x, quat_x);
        yy_reg <= mul_q30(quat_y, quat_y);
        zz_reg <= mul_q30(quat_z, quat_z);
        ww_reg <= mul_q30(quat_w, quat_w);
        xw_reg <= mul_q30(quat_x, quat_w);
        yz_reg <= mul_q30(quat_y, quat_z);
        xz_reg <= mul_q30(quat_x, quat_z);
        yw_reg <= mul_q30(quat_y, quat_w);
        zw_reg <= mul_q30(quat_z, quat_w);
        xy_reg <= mul_q30(quat_x, quat_y);
    end

    always_ff @(posedge clk)
    begin
        psi_y_reg <= (SW'(xw_reg) - SW'(yz_reg)) <<< 1;
        psi_x_reg <= SW'(ww_reg) - SW'(xx_reg) - SW'(yy_reg) + SW'(zz_reg);
        phi_y_reg <= (SW'(zw_reg) - SW'(xy_reg)) <<< 1;
        phi_x_reg <= SW'(ww_reg) + SW'(xx_reg) - SW'(yy_reg) - SW'(zz_reg);
        vsum_reg  <= (SW'(xz_reg) + SW'(yw_reg)) <<< 1;
    end

    // asin argument saturated to +/-1
    always_comb
    begin
        s3_next.psi_y   = psi_y_reg;
        s3_next.psi_x   = psi_x_reg;
        s3_next.phi_y   = phi_y_reg;
        s3_next.phi_x   = phi_x_reg;
        s3_next.clamped = 1'b0;
        s3_next.v       = VW'(vsum_reg);
        if (vsum_reg > q2e_pkg::Q30_ONE)
        begin
            s3_next.v       = VW'(q2e_pkg::Q30_ONE);
            s3_next.clamped = 1'b1;
        end
        else if (vsum_reg < -q2e_pkg::Q30_ONE)
        begin
            s3_next.v       = VW'(-q2e_pkg::Q30_ONE);
            s3_next.clamped = 1'b1;
        end
    end

    assign vmag = (s3_reg.v < 0) ? 31'(-s3_reg.v) : 31'(s3_reg.v);

    always_ff @(posedge clk)
    begin
        s3_reg  <= s3_next;
        vsq_reg <= vmag * vmag;
        s4_reg  <= s3_reg;
        rad_reg <= (q2e_pkg::ISQRT_W'(1) << 60) - q2e_pkg::ISQRT_W'(vsq_reg);
        s5_reg  <= s4_reg;
    end

    q2e_isqrt u_isqrt (
        .clk      (clk),
        .radicand (rad_reg),
        .root     (root)
    );

    always_ff @(posedge clk)
    begin
        side_dly_reg[0] <= s5_reg;
        for (int i = 1; i < q2e_pkg::ISQRT_STAGES; i++)
            side_dly_reg[i] <= side_dly_reg[i-1];
        clamp_dly_reg[0] <= side_dly_reg[SQ_LAST].clamped;
        for (int i = 1; i < q2e_pkg::ATAN_LAT; i++)
            clamp_dly_reg[i] <= clamp_dly_reg[i-1];
    end

    assign theta_y = SW'(side_dly_reg[SQ_LAST].v);
    assign theta_x = SW'({1'b0, root});

    q2e_atan2 u_atan_psi (
        .clk (clk),
        .y   (side_dly_reg[SQ_LAST].psi_y),
        .x   (side_dly_reg[SQ_LAST].psi_x),
        .z   (z_lane[0])
    );

    q2e_atan2 u_atan_theta (
        .clk (clk),
        .y   (theta_y),
        .x   (theta_x),
        .z   (z_lane[1])
    );

    q2e_atan2 u_atan_phi (
        .clk (clk),
        .y   (side_dly_reg[SQ_LAST].phi_y),
        .x   (side_dly_reg[SQ_LAST].phi_x),
        .z   (z_lane[2])
    );

    always_ff @(posedge clk)
    begin
        deg_e1_reg   <= deg_reg;
        clamp_e1_reg <= clamp_dly_reg[q2e_pkg::ATAN_LAT-1];
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
        always_ff @(posedge clk)
        begin
            if (deg_reg)
                scaled_reg[l] <= z_lane[l] * DEG_K;
            else
                scaled_reg[l] <= SC_W'(z_lane[l]);
        end

        // round to nearest, halves up, then wrap to the field width
        always_comb
        begin
            if (deg_e1_reg)
                rounded[l] = (scaled_reg[l] + RND_DEG) >>> (54 - ANGLE_FRAC_BITS);
            else
                rounded[l] = (scaled_reg[l] + RND_RAD) >>> (30 - ANGLE_FRAC_BITS);
        end

        always_ff @(posedge clk)
        begin
            angle_reg[l] <= rounded[l][AW-1:0];
        end
    end

    assign done         = vld_reg[TOTAL_LAT-1];
    assign angle_psi    = angle_reg[0];
    assign angle_theta  = angle_reg[1];
    assign angle_phi    = angle_reg[2];
    assign asin_clamped = clamp_out_reg;

    `Q2E_ASSERT_DLY(a_start_gives_done, clk, rst_n, start && !busy, TOTAL_LAT, done)
    `Q2E_ASSERT_IMP(a_done_had_start, clk, rst_n, done, $past(start, TOTAL_LAT))
    `Q2E_ASSERT_IMP(a_clamp_only_with_done, clk, rst_n, !done, !asin_clamped)

endmodule

/* src/q2e_isqrt.sv */
`timescale 1ns / 1ps

module q2e_isqrt (
    input  logic                              clk,
    input  logic [q2e_pkg::ISQRT_W-1:0]       radicand,
    output logic [q2e_pkg::ROOT_W-1:0]        root
);

    localparam int W = q2e_pkg::ISQRT_W;
    localparam int N = q2e_pkg::ISQRT_STAGES;

    logic [W-1:0] n_reg [N];
    logic [W-1:0] r_reg [N];

    // one result bit per stage, highest bit first
    for (genvar j = 0; j < N; j++) begin : g_stage
        localparam int K = N - 1 - j;
        localparam logic [W-1:0] BIT = W'(1) << (2 * K);
        logic [W-1:0] n_in;
        logic [W-1:0] r_in;
        logic [W-1:0] trial;
        logic [W-1:0] n_next;
        logic [W-1:0] r_next;

        if (j == 0) begin : g_first
            assign n_in = radicand;
            assign r_in = '0;
        end else begin : g_rest
            assign n_in = n_reg[j-1];
            assign r_in = r_reg[j-1];
        end

        assign trial = r_in + BIT;

        always_comb
        begin
            if (n_in >= trial)
            begin
                n_next = n_in - trial;
                r_next = (r_in >> 1) + BIT;
            end
            else
            begin
                n_next = n_in;
                r_next = r_in >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            n_reg[j] <= n_next;
            r_reg[j] <= r_next;
        end
    end

    assign root = r_reg[N-1][q2e_pkg::ROOT_W-1:0];

endmodule

/* src/q2e_atan2.sv */
`timescale 1ns / 1ps

module q2e_atan2 (
    input  logic                               clk,
    input  logic signed [q2e_pkg::SUM_W-1:0]   y,
    input  logic signed [q2e_pkg::SUM_W-1:0]   x,
    output logic signed [q2e_pkg::Z_W-1:0]     z
);

    localparam int W   = q2e_pkg::SUM_W;
    localparam int ZW  = q2e_pkg::Z_W;
    localparam int CW  = q2e_pkg::CORDIC_W;
    localparam int N   = q2e_pkg::CORDIC_ITERS;
    localparam int SHW = q2e_pkg::SH_W;

    // prepare stage
    logic signed [W-1:0]  xn_next, yn_next, yabs;
    logic [W-1:0]         mag_next;
    logic signed [ZW-1:0] z0_next, zfix_next;
    logic                 fix_next;

    logic signed [W-1:0]  xn_reg, yn_reg;
    logic [W-1:0]         mag_reg;
    logic signed [ZW-1:0] z0_reg, zfix_reg;
    logic                 fix_reg;

    // shift count stage
    logic [SHW-1:0]       pos;
    logic [SHW-1:0]       sh_next;
    logic [SHW-1:0]       sh_reg;
    logic signed [W-1:0]  xn2_reg, yn2_reg;
    logic signed [ZW-1:0] z02_reg, zfix2_reg;
    logic                 fix2_reg;

    // rotation stages
    logic signed [CW-1:0] cx_reg [N+1];
    logic signed [CW-1:0] cy_reg [N+1];
    logic signed [ZW-1:0] cz_reg [N+1];
    logic signed [ZW-1:0] zfix_d_reg [N+1];
    logic                 fix_d_reg [N+1];

    logic signed [ZW-1:0] zc;
    logic signed [ZW-1:0] z_reg;

    always_comb
    begin
        fix_next  = 1'b0;
        zfix_next = '0;
        if (y == 0)
        begin
            fix_next  = 1'b1;
            zfix_next = (x >= 0) ? '0 : q2e_pkg::Q30_PI;
        end
        else if (x == 0)
        begin
            fix_next  = 1'b1;
            zfix_next = (y > 0) ? q2e_pkg::Q30_HALF_PI : -q2e_pkg::Q30_HALF_PI;
        end

        // left half plane: rotate by pi first
        if (x < 0)
        begin
            xn_next = -x;
            yn_next = -y;
            z0_next = (y > 0) ? q2e_pkg::Q30_PI : -q2e_pkg::Q30_PI;
        end
        else
        begin
            xn_next = x;
            yn_next = y;
            z0_next = '0;
        end
        yabs     = (yn_next < 0) ? -yn_next : yn_next;
        mag_next = xn_next | yabs;
    end

    always_ff @(posedge clk)
    begin
        xn_reg   <= xn_next;
        yn_reg   <= yn_next;
        mag_reg  <= mag_next;
        z0_reg   <= z0_next;
        zfix_reg <= zfix_next;
        fix_reg  <= fix_next;
    end

    always_comb
    begin
        pos = '0;
        for (int i = 0; i < W; i++)
        begin
            if (mag_reg[i])
                pos = SHW'(i);
        end
        sh_next = SHW'(q2e_pkg::NORM_MSB - int'(pos));
    end

    always_ff @(posedge clk)
    begin
        sh_reg    <= sh_next;
        xn2_reg   <= xn_reg;
        yn2_reg   <= yn_reg;
        z02_reg   <= z0_reg;
        zfix2_reg <= zfix_reg;
        fix2_reg  <= fix_reg;
    end

    // scale up until the larger magnitude reaches bit 59
    always_ff @(posedge clk)
    begin
        cx_reg[0]     <= CW'(xn2_reg) <<< sh_reg;
        cy_reg[0]     <= CW'(yn2_reg) <<< sh_reg;
        cz_reg[0]     <= z02_reg;
        zfix_d_reg[0] <= zfix2_reg;
        fix_d_reg[0]  <= fix2_reg;
    end

    for (genvar i = 0; i < N; i++) begin : g_rot
        localparam logic signed [ZW-1:0] T = ZW'(q2e_pkg::atan_q30(i));
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;

        assign xs = cx_reg[i] >>> i;
        assign ys = cy_reg[i] >>> i;

        always_ff @(posedge clk)
        begin
            if (cy_reg[i] > 0)
            begin
                cx_reg[i+1] <= cx_reg[i] + ys;
                cy_reg[i+1] <= cy_reg[i] - xs;
                cz_reg[i+1] <= cz_reg[i] + T;
            end
            else
            begin
                cx_reg[i+1] <= cx_reg[i] - ys;
                cy_reg[i+1] <= cy_reg[i] + xs;
                cz_reg[i+1] <= cz_reg[i] - T;
            end
            zfix_d_reg[i+1] <= zfix_d_reg[i];
            fix_d_reg[i+1]  <= fix_d_reg[i];
        end
    end

    always_comb
    begin
        if (cz_reg[N] > q2e_pkg::Q30_PI)
            zc = q2e_pkg::Q30_PI;
        else if (cz_reg[N] < -q2e_pkg::Q30_PI)
            zc = -q2e_pkg::Q30_PI;
        else
            zc = cz_reg[N];
    end

    always_ff @(posedge clk)
    begin
        z_reg <= fix_d_reg[N] ? zfix_d_reg[N] : zc;
    end

    assign z = z_reg;

endmodule
